// ===== rtl/dbpskd_pkg.sv =====
// Shared constants, payload types and control bundles for the DBPSK symbol demodulator.
package dbpskd_pkg;

	// Fixed field widths
	localparam int SAMPLE_BITS = 16;
	localparam int SOFT_W      = 32;
	localparam int SPS_W       = 15;
	localparam int GAIN_W      = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;

	// Fixed-point formats
	localparam int SPS_FRAC  = 8;
	localparam int PROD_FRAC = 46;

	// Parameter defaults
	localparam int MAX_SPS_DEF     = 64;
	localparam int OFFSET_FRAC_DEF = 16;

	// Register reset values (10.0 samples per symbol, gain of about 0.01)
	localparam int SPS_RESET  = 2560;
	localparam int GAIN_RESET = 655;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_i;
		logic signed [SAMPLE_BITS-1:0] sample_q;
	} sample_t;

	typedef struct packed {
		logic signed [SOFT_W-1:0]      soft_bit;
		logic signed [SAMPLE_BITS-1:0] symbol_i;
		logic signed [SAMPLE_BITS-1:0] symbol_q;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take;
		logic mul_en;
		logic scale_en;
		logic offs_en;
		logic finish;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic decide;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/dbpskd_div.sv =====
// Two-lane bit-serial signed divider that averages the symbol sums by the sample count.
module dbpskd_div #(
	parameter int MAX_SPS = dbpskd_pkg::MAX_SPS_DEF,
	localparam int CNT_W = $clog2(MAX_SPS + 1),
	localparam int ACC_W = dbpskd_pkg::SAMPLE_BITS + CNT_W
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [ACC_W-1:0]               dividend_i,
	input  logic signed [ACC_W-1:0]               dividend_q,
	input  logic [CNT_W-1:0]                      divisor,
	output logic                                  done,
	output logic signed [dbpskd_pkg::SAMPLE_BITS-1:0] quot_i,
	output logic signed [dbpskd_pkg::SAMPLE_BITS-1:0] quot_q
);
	import dbpskd_pkg::*;

	localparam int STEP_W = $clog2(ACC_W);

	logic [ACC_W-1:0]  num_i_q, num_q_q;
	logic [CNT_W-1:0]  rem_i_q, rem_q_q;
	logic [CNT_W-1:0]  den_q;
	logic              neg_i_q, neg_q_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q, done_q;

	logic [ACC_W-1:0]  mag_i, mag_q;
	logic [ACC_W-1:0]  num_i_nx, num_q_nx;
	logic [CNT_W-1:0]  rem_i_nx, rem_q_nx;
	logic [ACC_W-1:0]  res_i, res_q;

	// One restoring step: shift in the next dividend bit, subtract when it fits
	function automatic logic [CNT_W+ACC_W-1:0] div_step(
		input logic [CNT_W-1:0] rem,
		input logic [ACC_W-1:0] num,
		input logic [CNT_W-1:0] den
	);
		logic [CNT_W:0] trial;
		logic [CNT_W:0] diff;
		trial = {rem, num[ACC_W-1]};
		diff  = trial - {1'b0, den};
		if (trial >= {1'b0, den}) begin
			return {diff[CNT_W-1:0], num[ACC_W-2:0], 1'b1};
		end else begin
			return {trial[CNT_W-1:0], num[ACC_W-2:0], 1'b0};
		end
	endfunction

	// Take magnitudes so the quotient truncates toward zero
	assign mag_i = dividend_i[ACC_W-1] ? ($unsigned(~dividend_i) + 1'b1) : $unsigned(dividend_i);
	assign mag_q = dividend_q[ACC_W-1] ? ($unsigned(~dividend_q) + 1'b1) : $unsigned(dividend_q);

	always_comb begin
		{rem_i_nx, num_i_nx} = div_step(rem_i_q, num_i_q, den_q);
		{rem_q_nx, num_q_nx} = div_step(rem_q_q, num_q_q, den_q);
	end

	// Restore the sign and keep the sample width
	assign res_i  = neg_i_q ? (~num_i_q + 1'b1) : num_i_q;
	assign res_q  = neg_q_q ? (~num_q_q + 1'b1) : num_q_q;
	assign quot_i = $signed(res_i[SAMPLE_BITS-1:0]);
	assign quot_q = $signed(res_q[SAMPLE_BITS-1:0]);
	assign done   = done_q;

	// Step counter: one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(ACC_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// Load operands, then shift the partial remainders and quotients
	always_ff @(posedge clk) begin
		if (start) begin
			num_i_q <= mag_i;
			num_q_q <= mag_q;
			rem_i_q <= '0;
			rem_q_q <= '0;
			den_q   <= divisor;
			neg_i_q <= dividend_i[ACC_W-1];
			neg_q_q <= dividend_q[ACC_W-1];
		end else if (busy_q) begin
			num_i_q <= num_i_nx;
			num_q_q <= num_q_nx;
			rem_i_q <= rem_i_nx;
			rem_q_q <= rem_q_nx;
		end
	end

endmodule

// ===== rtl/dbpskd_dp.sv =====
// Datapath: integrate-and-dump sums, symbol products, timing loop and result register.
module dbpskd_dp #(
	parameter int MAX_SPS          = dbpskd_pkg::MAX_SPS_DEF,
	parameter int OFFSET_FRAC_BITS = dbpskd_pkg::OFFSET_FRAC_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dbpskd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dbpskd_pkg::CFG_W-1:0]       cfg_data,
	input  dbpskd_pkg::sample_t                in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output dbpskd_pkg::result_t                out_data,
	input  dbpskd_pkg::dp_cmd_t                cmd,
	output dbpskd_pkg::dp_stat_t               stat
);
	import dbpskd_pkg::*;

	localparam int CNT_W  = $clog2(MAX_SPS + 1);
	localparam int ACC_W  = SAMPLE_BITS + CNT_W;
	localparam int OFF_W  = OFFSET_FRAC_BITS + 4;
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int ERR_W  = DIFF_W + SAMPLE_BITS;
	localparam int PROD_W = GAIN_W + 1 + ERR_W;
	localparam int SH     = PROD_FRAC - OFFSET_FRAC_BITS;
	localparam int TS_W   = OFFSET_FRAC_BITS + 9;
	localparam int SUM_W  = SOFT_W + 1;

	// Symbol length after reset: round(samples_per_symbol) with a zero offset
	localparam int LEN_RAW   = (SPS_RESET + (1 << (SPS_FRAC - 1))) >> SPS_FRAC;
	localparam int LEN_RESET = (LEN_RAW < 1) ? 1 : ((LEN_RAW > MAX_SPS) ? MAX_SPS : LEN_RAW);

	localparam logic signed [PROD_W-1:0] RND_C = PROD_W'(64'sd1 <<< (SH - 1));
	localparam logic signed [PROD_W-1:0] OMAX  = PROD_W'((64'sd1 <<< (OFF_W - 1)) - 64'sd1);
	localparam logic signed [PROD_W-1:0] OMIN  = PROD_W'(-(64'sd1 <<< (OFF_W - 1)));
	localparam logic signed [TS_W-1:0]   TS_HALF = TS_W'(64'sd1 <<< (OFFSET_FRAC_BITS - 1));
	localparam logic signed [TS_W-1:0]   T_ONE   = TS_W'(64'sd1);
	localparam logic signed [TS_W-1:0]   T_MAX   = TS_W'(MAX_SPS);
	localparam logic signed [OFF_W-1:0]  OFF_HALF  = OFF_W'(64'sd1 <<< (OFFSET_FRAC_BITS - 1));
	localparam logic signed [OFF_W-1:0]  OFF_NHALF = OFF_W'(-(64'sd1 <<< (OFFSET_FRAC_BITS - 1)));
	localparam logic signed [OFF_W-1:0]  OFF_ONE   = OFF_W'(64'sd1 <<< OFFSET_FRAC_BITS);
	localparam logic signed [SOFT_W-1:0] SOFT_MAX  = {1'b0, {(SOFT_W-1){1'b1}}};
	localparam logic signed [SOFT_W-1:0] SOFT_MIN  = {1'b1, {(SOFT_W-1){1'b0}}};

	// Configuration registers
	logic [SPS_W-1:0]  sps_q;
	logic [GAIN_W-1:0] gain_q;

	// Loop state
	logic signed [ACC_W-1:0]       acc_re_q, acc_im_q;
	logic [CNT_W-1:0]              cnt_q, len_q;
	logic signed [OFF_W-1:0]       off_q;
	logic                          skip_q;
	logic signed [SAMPLE_BITS-1:0] last_smp_q;
	logic signed [SAMPLE_BITS-1:0] last_sym_re_q, last_sym_im_q;

	// Per-symbol working registers
	logic signed [SAMPLE_BITS-1:0] err_smp_q;
	logic signed [SAMPLE_BITS-1:0] sym_i_q, sym_q_q;
	logic signed [SOFT_W-1:0]      prod_ii_s1, prod_qq_s1;
	logic signed [ERR_W-1:0]       err_s1;
	logic signed [SOFT_W-1:0]      soft_s2;
	logic signed [PROD_W-1:0]      scaled_s2;
	logic signed [OFF_W-1:0]       off_s3;
	result_t                       out_q;
	logic                          out_valid_q;

	// Combinational terms
	logic [CNT_W-1:0]              cnt_inc;
	logic signed [ACC_W-1:0]       sum_re, sum_im;
	logic                          div_start, div_done;
	logic signed [SAMPLE_BITS-1:0] quot_i, quot_q;
	logic signed [DIFF_W-1:0]      diff;
	logic signed [SUM_W-1:0]       soft_sum;
	logic signed [SOFT_W-1:0]      soft_sat;
	logic signed [PROD_W-1:0]      rnd, delta, osum;
	logic signed [OFF_W-1:0]       off_clamp;
	logic signed [TS_W-1:0]        sps_ext, tsum, tlen;
	logic [CNT_W-1:0]              len_nx;
	logic signed [OFF_W-1:0]       off_wrap;
	logic                          skip_set;

	// Accumulate or decide on the incoming sample
	assign cnt_inc   = cnt_q + 1'b1;
	assign sum_re    = acc_re_q + ACC_W'(in_data.sample_i);
	assign sum_im    = acc_im_q + ACC_W'(in_data.sample_q);
	assign div_start = cmd.take && stat.decide;

	assign stat.decide   = !skip_q && (cnt_inc >= len_q);
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || !out_stall;

	dbpskd_div #(
		.MAX_SPS (MAX_SPS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.dividend_i (sum_re),
		.dividend_q (sum_im),
		.divisor    (cnt_inc),
		.done       (div_done),
		.quot_i     (quot_i),
		.quot_q     (quot_q)
	);

	// Difference of the new symbol's real part against the previous one
	assign diff = DIFF_W'(quot_i) - DIFF_W'(last_sym_re_q);

	// Saturate the soft bit sum to 32 bits
	always_comb begin
		soft_sum = SUM_W'(prod_ii_s1) + SUM_W'(prod_qq_s1);
		if (soft_sum[SUM_W-1] != soft_sum[SUM_W-2]) begin
			soft_sat = soft_sum[SUM_W-1] ? SOFT_MIN : SOFT_MAX;
		end else begin
			soft_sat = soft_sum[SOFT_W-1:0];
		end
	end

	// Round the scaled error, add to the offset and saturate
	always_comb begin
		rnd   = scaled_s2 + RND_C;
		delta = rnd >>> SH;
		osum  = delta + PROD_W'(off_q);
		if (osum > OMAX) begin
			off_clamp = OMAX[OFF_W-1:0];
		end else if (osum < OMIN) begin
			off_clamp = OMIN[OFF_W-1:0];
		end else begin
			off_clamp = osum[OFF_W-1:0];
		end
	end

	// Next symbol length from the unwrapped offset, then wrap the offset
	always_comb begin
		sps_ext = $signed(TS_W'(sps_q) << (OFFSET_FRAC_BITS - SPS_FRAC));
		tsum    = sps_ext + TS_W'(off_s3) + TS_HALF;
		tlen    = tsum >>> OFFSET_FRAC_BITS;
		if (tlen < T_ONE) begin
			len_nx = CNT_W'(1);
		end else if (tlen > T_MAX) begin
			len_nx = CNT_W'(MAX_SPS);
		end else begin
			len_nx = tlen[CNT_W-1:0];
		end
		skip_set = 1'b0;
		if (off_s3 > OFF_HALF) begin
			off_wrap = off_s3 - OFF_ONE;
			skip_set = 1'b1;
		end else if (off_s3 < OFF_NHALF) begin
			off_wrap = off_s3 + OFF_ONE;
		end else begin
			off_wrap = off_s3;
		end
	end

	// Configuration, loop state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sps_q         <= SPS_W'(SPS_RESET);
			gain_q        <= GAIN_W'(GAIN_RESET);
			acc_re_q      <= '0;
			acc_im_q      <= '0;
			cnt_q         <= '0;
			len_q         <= CNT_W'(LEN_RESET);
			off_q         <= '0;
			skip_q        <= 1'b0;
			last_smp_q    <= '0;
			last_sym_re_q <= '0;
			last_sym_im_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SPS:  sps_q  <= cfg_data[SPS_W-1:0];
					REG_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
					default:  ;
				endcase
			end
			if (cmd.take) begin
				last_smp_q <= in_data.sample_i;
				if (skip_q) begin
					// drop the sample
					skip_q <= 1'b0;
				end else if (stat.decide) begin
					acc_re_q <= '0;
					acc_im_q <= '0;
					cnt_q    <= '0;
				end else begin
					acc_re_q <= sum_re;
					acc_im_q <= sum_im;
					cnt_q    <= cnt_inc;
				end
			end
			if (cmd.finish) begin
				off_q         <= off_wrap;
				skip_q        <= skip_set;
				len_q         <= len_nx;
				last_sym_re_q <= sym_i_q;
				last_sym_im_q <= sym_q_q;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Symbol pipeline and result payload
	always_ff @(posedge clk) begin
		if (div_start) begin
			err_smp_q <= last_smp_q;
		end
		if (cmd.mul_en) begin
			sym_i_q    <= quot_i;
			sym_q_q    <= quot_q;
			prod_ii_s1 <= quot_i * last_sym_re_q;
			prod_qq_s1 <= quot_q * last_sym_im_q;
			err_s1     <= diff * err_smp_q;
		end
		if (cmd.scale_en) begin
			soft_s2   <= soft_sat;
			scaled_s2 <= $signed({1'b0, gain_q}) * err_s1;
		end
		if (cmd.offs_en) begin
			off_s3 <= off_clamp;
		end
		if (cmd.finish) begin
			out_q.soft_bit <= soft_s2;
			out_q.symbol_i <= sym_i_q;
			out_q.symbol_q <= sym_q_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/dbpskd_ctrl.sv =====
// Controller: sequences the symbol decision through divide, multiply and loop update.
module dbpskd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output dbpskd_pkg::dp_cmd_t   cmd,
	input  dbpskd_pkg::dp_stat_t  stat
);
	import dbpskd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_SCALE,
		ST_OFFS,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic   stall_q;

	// Commands decoded from state
	always_comb begin
		cmd.take     = in_valid && !stall_q;
		cmd.mul_en   = (state_q == ST_MUL);
		cmd.scale_en = (state_q == ST_SCALE);
		cmd.offs_en  = (state_q == ST_OFFS);
		cmd.finish   = (state_q == ST_UPDATE) && stat.out_free;
	end

	// Advance through the decision steps; hold input requests until done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.take && stat.decide) begin
						state_q <= ST_DIV;
						stall_q <= 1'b1;
					end
				end
				ST_DIV: begin
					if (stat.div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:   state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_OFFS;
				ST_OFFS:  state_q <= ST_UPDATE;
				ST_UPDATE: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_stall = stall_q;

endmodule

// ===== rtl/dbpsk_symbol_demodulator_top.sv =====
// Top level of the DBPSK integrate-and-dump symbol demodulator with timing loop.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_stall  | in_data  : sample_i, sample_q (Q1.15)
//  out      | out_valid / out_stall| out_data : soft_bit (Q2.30), symbol_i/q
//  cfg      | cfg_we               | cfg_index, cfg_data
//
// Samples that do not end a symbol stream at one per clock while in_stall is low.
// A sample that ends a symbol holds in_stall until its result is loaded: the bit-serial
// averaging divider produces one quotient bit per accumulator bit and hands its quotient
// over, then multiply, gain scaling, offset update and result load follow; the result
// load also waits for the output register to be free.
// Reset clears all loop state at once; the symbol length starts at round(10.0) = 10.
// A result waits in the output register under out_stall while new samples keep arriving;
// only the result load of the next symbol decision waits for that register to be free.
module dbpsk_symbol_demodulator_top #(
	parameter int MAX_SPS          = dbpskd_pkg::MAX_SPS_DEF,
	parameter int OFFSET_FRAC_BITS = dbpskd_pkg::OFFSET_FRAC_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dbpskd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dbpskd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  dbpskd_pkg::sample_t              in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output dbpskd_pkg::result_t              out_data
);
	import dbpskd_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	dbpskd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	dbpskd_dp #(
		.MAX_SPS          (MAX_SPS),
		.OFFSET_FRAC_BITS (OFFSET_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

	// A symbol decision blocks further requests until its result is loaded
	a_decide_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && stat.decide |=> in_stall)
		else $error("input not stalled after symbol decision");

	// A new result only comes out of a decision sequence
	a_result_from_decision: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a symbol decision");

	// The divider only finishes while a decision is in flight
	a_div_in_decision: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> in_stall)
		else $error("divider finished outside a symbol decision");

endmodule
